@@ design/nrte_pkg.sv @@
`default_nettype none
package nrte_pkg;
  localparam int NODES = 30;
  localparam logic [7:0] NO_METRIC = 8'd255;
  localparam logic [7:0] MAX_GOOD_METRIC = 8'd15;

  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_BEACON = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_LOOKUP = 3'd3;
  localparam logic [2:0] CMD_RIP    = 3'd4;
  localparam logic [2:0] CMD_TIDY   = 3'd5;
  localparam logic [2:0] CMD_DROP   = 3'd6;
  localparam logic [2:0] CMD_QUERY  = 3'd7;

  localparam logic [0:0] CFG_OWN_ID    = 1'd0;
  localparam logic [0:0] CFG_BROADCAST = 1'd1;

  // Operation held for a table sweep and given to every route cell.
  typedef struct packed {
    logic [2:0] op;
    logic [4:0] id;
    logic [4:0] own;
    logic       nb_ok;
  } sweep_t;

  // One route entry as it moves from cell to cell.
  typedef struct packed {
    logic       valid;
    logic [7:0] hop;
    logic [7:0] metric;
  } route_t;
endpackage
`default_nettype wire

@@ design/neighbor_route_table_engine.sv @@
`default_nettype none
// Routing table for up to 30 node ids kept as a ring of route cells.
// Init, beacon, remove, tidy and the last RIP entry of a packet from a
// neighbor rotate the ring once, one entry per cycle, in ST_SWEEP and then
// post their result word via ST_DONE; lookup, query, drop, other RIP entries
// and commands rejected for a bad id go straight to ST_DONE. The single route
// cell read and written at the ring head sets the rate. The result word waits
// in an output register; the next word is accepted the cycle after it is taken.
module neighbor_route_table_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: command[2:0], node_id[7:3], neighbor_bitmap[39:8], rip_dst[47:40],
  // rip_metric[55:48]
  input  wire logic [55:0] s_tdata,
  input  wire logic        s_tlast,   // rip_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: route_hop[7:0], is_neighbor[8], id_error[9], zero fill [15:10]
  output logic [15:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  localparam int N = nrte_pkg::NODES;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]  state;
  logic [4:0]  own_id;
  logic [7:0]  bcast;
  logic [31:0] nmap;
  logic [N-1:0] seen;
  logic [7:0]  rbuf [N];
  logic [4:0]  cnt;
  logic [4:0]  head;
  nrte_pkg::sweep_t sw;
  logic [31:0] bmap;
  nrte_pkg::route_t ring [N];
  nrte_pkg::route_t rin [N];
  logic        shift;
  logic [9:0]  res;
  logic        out_full;

  logic [2:0]  cmd;
  logic [4:0]  nid;
  logic [7:0]  rdst;
  logic [7:0]  rmet;
  logic        id_ok, own_ok, dst_ok;
  logic [4:0]  nidx, didx;

  assign cmd  = s_tdata[2:0];
  assign nid  = s_tdata[7:3];
  assign rdst = s_tdata[47:40];
  assign rmet = s_tdata[55:48];
  assign id_ok  = nid >= 5'd1 && nid <= 5'(N);
  assign own_ok = own_id >= 5'd1 && own_id <= 5'(N);
  assign dst_ok = rdst >= 8'd1 && rdst <= 8'(N);
  assign nidx = nid - 5'd1;
  assign didx = rdst[4:0] - 5'd1;

  assign s_tready  = state == ST_IDLE && !out_full;
  assign cfg_ready = state == ST_IDLE;
  assign m_tvalid  = out_full;
  assign m_tdata   = {6'd0, res};
  assign shift     = state == ST_SWEEP;

  // Ring: entry i moves to slot i-1; slot 0 wraps to slot N-1 through the
  // active head cell, which thus sees destinations in order 1..N.
  for (genvar g = 0; g < N; g++) begin : g_ring
    if (g == N - 1) begin : g_w
      assign rin[g] = ring[0];
    end else begin : g_s
      assign rin[g] = ring[g+1];
    end
    nrte_cell u_cell (
      .clk(clk), .rst(rst), .shift(shift), .apply(g == N - 1), .sw(sw),
      .pos(head + 5'd1),
      .bm_bit(bmap[head]), .nb_bit(nmap[head]), .seen_bit(seen[head]),
      .buf_metric(rbuf[head]), .din(rin[g]), .dout(ring[g]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      own_id <= 5'd1;
      bcast <= 8'd255;
      nmap <= '0;
      seen <= '0;
      out_full <= 1'b0;
      cnt <= '0;
      head <= '0;
    end else begin
      if (m_tvalid && m_tready) out_full <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          nrte_pkg::CFG_OWN_ID:    own_id <= cfg_data[4:0];
          nrte_pkg::CFG_BROADCAST: bcast <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            res <= '0;
            state <= ST_DONE;
            sw.op <= cmd;
            sw.id <= nid;
            sw.own <= own_id;
            sw.nb_ok <= nmap[nidx];
            bmap <= s_tdata[39:8];
            cnt <= '0;
            head <= '0;
            if (cmd == nrte_pkg::CMD_INIT) begin
              if (!own_ok) res[9] <= 1'b1;
              else begin
                nmap <= 32'd1 << (own_id - 5'd1);
                state <= ST_SWEEP;
              end
            end else if (cmd == nrte_pkg::CMD_TIDY) begin
              state <= ST_SWEEP;
            end else if (!id_ok) begin
              res[9] <= 1'b1;
            end else begin
              unique case (cmd)
                nrte_pkg::CMD_BEACON, nrte_pkg::CMD_REMOVE: state <= ST_SWEEP;
                nrte_pkg::CMD_LOOKUP: res[7:0] <= ring[nidx].valid ?
                                                  ring[nidx].hop : bcast;
                nrte_pkg::CMD_RIP: begin
                  if (dst_ok && !seen[didx]) begin
                    rbuf[didx] <= rmet;
                  end
                  if (s_tlast) begin
                    if (nmap[nidx]) begin
                      state <= ST_SWEEP;
                      if (dst_ok) seen[didx] <= 1'b1;
                    end else seen <= '0;
                  end else if (dst_ok) seen[didx] <= 1'b1;
                end
                nrte_pkg::CMD_DROP: nmap[nidx] <= 1'b0;
                nrte_pkg::CMD_QUERY: res[8] <= nmap[nidx];
                default: ;
              endcase
            end
          end
        end
        ST_SWEEP: begin
          head <= head + 5'd1;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(N - 1)) begin
            state <= ST_DONE;
            if (sw.op == nrte_pkg::CMD_RIP) seen <= '0;
            if (sw.op == nrte_pkg::CMD_BEACON) nmap[sw.id - 5'd1] <= 1'b1;
          end
        end
        ST_DONE: begin
          out_full <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_sweep: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> !s_tready) else $error("accept during sweep");
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> m_tvalid) else $error("result not posted");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> cnt < 5'(N)) else $error("sweep overrun");
`endif
endmodule
`default_nettype wire

@@ design/nrte_cell.sv @@
`default_nettype none
// One slot of the rotating route ring. Each sweep cycle the entry shifts one
// place; the cell at the ring head applies the current command to the entry it
// hands on, so after NODES shifts every entry has been visited once.
module nrte_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             shift,
  input  wire logic             apply,
  input  wire nrte_pkg::sweep_t sw,
  input  wire logic [4:0]       pos,
  input  wire logic             bm_bit,
  input  wire logic             nb_bit,
  input  wire logic             seen_bit,
  input  wire logic [7:0]       buf_metric,
  input  wire nrte_pkg::route_t din,
  output nrte_pkg::route_t      dout
);
  nrte_pkg::route_t ent;
  nrte_pkg::route_t ent_next;
  nrte_pkg::route_t clr;

  assign dout = ent;

  always_comb begin
    clr.valid  = 1'b0;
    clr.hop    = 8'd0;
    clr.metric = nrte_pkg::NO_METRIC;
    ent_next   = din;
    if (apply) begin
      unique case (sw.op)
        nrte_pkg::CMD_INIT: begin
          if (pos == sw.own) begin
            ent_next.valid  = 1'b1;
            ent_next.hop    = {3'd0, sw.own};
            ent_next.metric = 8'd0;
          end else begin
            ent_next = clr;
          end
        end
        nrte_pkg::CMD_TIDY: begin
          if (din.valid && (din.hop > 8'(nrte_pkg::NODES) ||
              (din.metric > nrte_pkg::MAX_GOOD_METRIC &&
               din.metric != nrte_pkg::NO_METRIC)))
            ent_next = clr;
        end
        nrte_pkg::CMD_BEACON: begin
          if (pos == sw.id && !sw.nb_ok) begin
            ent_next.valid  = 1'b1;
            ent_next.hop    = {3'd0, sw.id};
            ent_next.metric = 8'd1;
          end else if (bm_bit && !nb_bit) begin
            ent_next.valid  = 1'b1;
            ent_next.hop    = {3'd0, sw.id};
            ent_next.metric = 8'd2;
          end
        end
        nrte_pkg::CMD_REMOVE: begin
          if (din.hop == {3'd0, sw.id}) ent_next = clr;
        end
        nrte_pkg::CMD_RIP: begin
          if (!din.valid && seen_bit && din.hop != {3'd0, sw.own}) begin
            ent_next.valid  = 1'b1;
            ent_next.hop    = {3'd0, sw.id};
            ent_next.metric = buf_metric + 8'd1;
          end else if (din.valid && !seen_bit && din.hop == {3'd0, sw.id}) begin
            ent_next = clr;
          end
        end
        default: ent_next = din;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ent <= {1'b0, 8'd0, nrte_pkg::NO_METRIC};
    else if (shift) ent <= ent_next;
  end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  neighbor_route_table_engine DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic       last;
    logic [7:0] rmet;
    logic [7:0] rdst;
    logic [31:0] bmap;
    logic [4:0] id;
    logic [2:0] cmd;
  } cmd_word_t;

  // Predicted table state.
  logic [4:0]  tab_own;
  logic [7:0]  tab_bcast;
  logic [31:0] tab_nbr;
  logic        tab_valid [nrte_pkg::NODES];
  logic [7:0]  tab_hop [nrte_pkg::NODES];
  logic [7:0]  tab_met [nrte_pkg::NODES];
  logic [31:0] tab_seen;
  logic [7:0]  tab_buf [nrte_pkg::NODES];

  cmd_word_t  pending_words[$];
  logic [15:0] expected_words[$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit tx_hold = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;

  function automatic bit id_good(logic [7:0] v);
    return v >= 1 && v <= nrte_pkg::NODES;
  endfunction

  task automatic drop_route(int i);
    tab_valid[i] = 1'b0;
    tab_hop[i] = 8'd0;
    tab_met[i] = nrte_pkg::NO_METRIC;
  endtask

  task automatic put_route(int i, logic [7:0] hop, logic [7:0] met);
    tab_valid[i] = 1'b1;
    tab_hop[i] = hop;
    tab_met[i] = met;
  endtask

  task automatic route_table_apply(cmd_word_t w);
    logic [7:0] hop;
    logic nb;
    logic err;
    logic [31:0] b;
    bit found;
    hop = 8'd0; nb = 1'b0; err = 1'b0;
    if (w.cmd == nrte_pkg::CMD_INIT) begin
      if (!id_good({3'd0, tab_own})) err = 1'b1;
      else begin
        tab_nbr = 32'd1 << (tab_own - 1);
        for (int i = 0; i < nrte_pkg::NODES; i++)
          if (i + 1 == tab_own) put_route(i, {3'd0, tab_own}, 8'd0);
          else drop_route(i);
      end
    end else if (w.cmd == nrte_pkg::CMD_TIDY) begin
      for (int i = 0; i < nrte_pkg::NODES; i++)
        if (tab_valid[i] && (tab_hop[i] > nrte_pkg::NODES ||
            (tab_met[i] > nrte_pkg::MAX_GOOD_METRIC && tab_met[i] != nrte_pkg::NO_METRIC)))
          drop_route(i);
    end else if (!id_good({3'd0, w.id})) begin
      err = 1'b1;
    end else begin
      b = 32'd1 << (w.id - 1);
      case (w.cmd)
        nrte_pkg::CMD_BEACON: begin
          if ((tab_nbr & b) == 0) begin
            tab_nbr |= b;
            put_route(w.id - 1, {3'd0, w.id}, 8'd1);
          end
          for (int i = 0; i < nrte_pkg::NODES; i++)
            if (w.bmap[i] && !tab_nbr[i]) put_route(i, {3'd0, w.id}, 8'd2);
        end
        nrte_pkg::CMD_REMOVE: begin
          for (int i = 0; i < nrte_pkg::NODES; i++)
            if (tab_hop[i] == {3'd0, w.id}) drop_route(i);
        end
        nrte_pkg::CMD_LOOKUP: hop = tab_valid[w.id - 1] ? tab_hop[w.id - 1] : tab_bcast;
        nrte_pkg::CMD_RIP: begin
          if (id_good(w.rdst) && !tab_seen[w.rdst - 1]) begin
            tab_seen[w.rdst - 1] = 1'b1;
            tab_buf[w.rdst - 1] = w.rmet;
          end
          if (w.last) begin
            if ((tab_nbr & b) != 0)
              for (int i = 0; i < nrte_pkg::NODES; i++) begin
                found = tab_seen[i];
                if (!tab_valid[i] && found && tab_hop[i] != {3'd0, tab_own})
                  put_route(i, {3'd0, w.id}, tab_buf[i] + 8'd1);
                else if (tab_valid[i] && !found && tab_hop[i] == {3'd0, w.id})
                  drop_route(i);
              end
            tab_seen = '0;
          end
        end
        nrte_pkg::CMD_DROP: tab_nbr &= ~b;
        default: nb = (tab_nbr & b) != 0;
      endcase
    end
    expected_words.push_back({6'd0, err, nb, hop});
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Sender: one word per handshake, gaps drawn between words.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        route_table_apply(pending_words.pop_front());
        tx_gap = pick_gap();
      end
      if ((!s_tvalid || s_tready) ) begin
        if (pending_words.size() > 0 && !tx_hold && tx_gap == 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_words[0][55:0];
          s_tlast <= pending_words[0].last;
        end else begin
          s_tvalid <= 1'b0;
          if (tx_gap > 0) tx_gap--;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
        end else begin
          logic [15:0] e;
          e = expected_words.pop_front();
          if (e[7:0] !== m_tdata[7:0] || e[8] !== m_tdata[8] || e[9] !== m_tdata[9] ||
              m_tdata[15:10] !== 6'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected hop %0d nb %0d err %0d,",
                        " got hop %0d nb %0d err %0d"},
                       e[7:0], e[8], e[9], m_tdata[7:0], m_tdata[8], m_tdata[9]);
          end
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 5) == 0) rx_gap = pick_gap();
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[neighbor_route_table_engine] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == nrte_pkg::CFG_OWN_ID) tab_own = val[4:0];
    else tab_bcast = val;
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || s_tvalid || expected_words.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic cmd_word_t make_word(logic [2:0] c, logic [4:0] id, logic [31:0] bm,
                                          logic [7:0] d, logic [7:0] m, logic l);
    cmd_word_t w;
    w.cmd = c; w.id = id; w.bmap = bm; w.rdst = d; w.rmet = m; w.last = l;
    return w;
  endfunction

  // Mostly well-formed traffic: valid ids, rip entries grouped into packets.
  task automatic queue_random(int n);
    cmd_word_t w;
    int k;
    for (int j = 0; j < n; j++) begin
      w = cmd_word_t'(57'({$urandom, $urandom}));
      if ($urandom_range(0, 9) != 0) w.id = 5'($urandom_range(1, nrte_pkg::NODES));
      if (w.cmd == nrte_pkg::CMD_INIT && $urandom_range(0, 3) != 0)
        w.cmd = nrte_pkg::CMD_BEACON;
      if (w.cmd == nrte_pkg::CMD_RIP && $urandom_range(0, 2) != 0) begin
        k = $urandom_range(1, 6);
        for (int q = 0; q < k; q++) begin
          w.rdst = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                                                 8'($urandom_range(1, nrte_pkg::NODES));
          w.rmet = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
          w.last = (q == k - 1);
          pending_words.push_back(w);
        end
        j += k - 1;
      end else
        pending_words.push_back(w);
    end
  endtask

  task automatic queue_cmd(logic [2:0] c, logic [4:0] id, logic [31:0] bm,
                           logic [7:0] d, logic [7:0] m, logic l);
    pending_words.push_back(make_word(c, id, bm, d, m, l));
  endtask

  initial begin
    tab_own = 5'd1; tab_bcast = 8'd255; tab_nbr = '0; tab_seen = '0;
    for (int i = 0; i < nrte_pkg::NODES; i++) begin
      drop_route(i);
      tab_buf[i] = 8'd0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(nrte_pkg::CFG_OWN_ID, 8'd1);
    write_reg(nrte_pkg::CFG_BROADCAST, 8'd255);
    // Directed checks.
    queue_cmd(nrte_pkg::CMD_INIT, 5'd0, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_BEACON, 5'd2, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_BEACON, 5'd30, 32'h0000_0010, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_BEACON, 5'd0, 32'hFFFF_FFFF, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_BEACON, 5'd31, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_LOOKUP, 5'd5, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_LOOKUP, 5'd0, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_REMOVE, 5'd30, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_LOOKUP, 5'd5, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_QUERY, 5'd2, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_RIP, 5'd2, 32'd0, 8'd7, 8'd255, 1'b0);
    queue_cmd(nrte_pkg::CMD_RIP, 5'd2, 32'd0, 8'd7, 8'd3, 1'b0);
    queue_cmd(nrte_pkg::CMD_RIP, 5'd31, 32'd0, 8'd8, 8'd3, 1'b1);
    queue_cmd(nrte_pkg::CMD_RIP, 5'd2, 32'd0, 8'd200, 8'd0, 1'b1);
    queue_cmd(nrte_pkg::CMD_RIP, 5'd9, 32'd0, 8'd12, 8'd1, 1'b1);
    queue_cmd(nrte_pkg::CMD_TIDY, 5'd0, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_DROP, 5'd2, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_QUERY, 5'd2, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_DROP, 5'd31, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_QUERY, 5'd0, 32'd0, 8'd0, 8'd0, 1'b0);
    wait_drained();
    write_reg(nrte_pkg::CFG_OWN_ID, 8'd0);
    queue_cmd(nrte_pkg::CMD_INIT, 5'd0, 32'd0, 8'd0, 8'd0, 1'b0);
    wait_drained();
    write_reg(nrte_pkg::CFG_OWN_ID, 8'd31);
    write_reg(nrte_pkg::CFG_BROADCAST, 8'd0);
    queue_cmd(nrte_pkg::CMD_INIT, 5'd0, 32'd0, 8'd0, 8'd0, 1'b0);
    queue_cmd(nrte_pkg::CMD_LOOKUP, 5'd3, 32'd0, 8'd0, 8'd0, 1'b0);
    wait_drained();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(nrte_pkg::CFG_OWN_ID,
                ph == 0 ? 8'd30 : 8'($urandom_range(1, nrte_pkg::NODES)));
      write_reg(nrte_pkg::CFG_BROADCAST, 8'($urandom));
      queue_cmd(nrte_pkg::CMD_INIT, 5'd0, 32'd0, 8'd0, 8'd0, 1'b0);
      queue_random(220);
      while (pending_words.size() > 110) @(posedge clk);
      // Hold off the sender until every result is in.
      tx_hold = 1'b1;
      while (expected_words.size() > 0 || s_tvalid) @(posedge clk);
      tx_hold = 1'b0;
      queue_random(220);
      wait_drained();
    end
    $display("Covered %0d result words over several own-id and broadcast settings.",
             results_seen);
    if (mismatches == 0)
      $display("[neighbor_route_table_engine] OK");
    else
      $display("[neighbor_route_table_engine] ERROR");
    $finish;
  end
endmodule
